FILE: design/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [15:0] CP_2BYTE_MIN = 16'h0080;
  localparam logic [15:0] CP_3BYTE_MIN = 16'h0800;

  // {bad, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/jsu_if.sv
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input status,
                input last, output ready);
endinterface
`default_nettype wire

FILE: design/json_string_unescape.sv
// Streaming decoder for one quoted JSON string, one raw byte per transfer.
// in_ch carries in_byte and text_end; out_ch carries out_byte, byte_valid,
// status (continuing, complete, error) and last, which marks the final
// result caused by one input byte.
// Each accepted byte gives 0 to 3 results. They are decoded in the cycle of
// the input transfer and held in a three-slot result buffer, so the first
// result appears in the cycle after the input transfer.
// Throughput is one input byte per cycle while the receiver takes every
// result: a new byte is accepted while the last buffered result leaves.
// A \u escape that encodes to two or three UTF-8 bytes holds in_ch.ready
// low while the buffer drains.
// When the receiver stalls, the buffered results hold and in_ch.ready
// stays low until the last of them is transferred.
// Reset (rst_n low, synchronous) empties the result buffer and returns the
// decoder to idle, awaiting an opening quote, with the code cleared.
`default_nettype none
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] code_r, code_nxt;
  logic [1:0]  rem_r;

  // slot 0 carries any status; slots 1 and 2 are always decoded bytes
  logic [7:0]  s0_byte_r, s1_byte_r, s2_byte_r;
  logic        s0_valid_r;
  status_t     s0_status_r;

  logic [1:0]  n_nxt;
  logic [7:0]  b0_nxt, b1_nxt, b2_nxt;
  logic        v0_nxt;
  status_t     st0_nxt;
  logic [4:0]  hv;
  logic [15:0] cp;
  logic        in_xfer, out_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = (rem_r != 2'd0);
  assign out_ch.out_byte   = s0_byte_r;
  assign out_ch.byte_valid = s0_valid_r;
  assign out_ch.status     = s0_status_r;
  assign out_ch.last       = (rem_r == 2'd1);

  assign hv = hex_val(in_ch.in_byte);
  assign cp = {code_r[11:0], hv[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    n_nxt     = 2'd0;
    b0_nxt    = 8'h00;
    b1_nxt    = 8'h00;
    b2_nxt    = 8'h00;
    v0_nxt    = 1'b0;
    st0_nxt   = ST_CONT;
    if (in_ch.text_end) begin
      phase_nxt = PH_IDLE;
      code_nxt  = 16'h0000;
      n_nxt     = 2'd1;
      st0_nxt   = ST_ERR;
    end else begin
      case (phase_r)
        PH_BODY: begin
          if (in_ch.in_byte == CH_QUOTE) begin
            phase_nxt = PH_IDLE;
            n_nxt     = 2'd1;
            st0_nxt   = ST_DONE;
          end else if (in_ch.in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            n_nxt  = 2'd1;
            b0_nxt = in_ch.in_byte;
            v0_nxt = 1'b1;
          end
        end
        PH_ESC: begin
          if (in_ch.in_byte == CH_U) begin
            phase_nxt = PH_HEX1;
            code_nxt  = 16'h0000;
          end else begin
            phase_nxt = PH_BODY;
            n_nxt     = 2'd1;
            v0_nxt    = 1'b1;
            case (in_ch.in_byte)
              CH_N:    b0_nxt = 8'h0A;
              CH_T:    b0_nxt = 8'h09;
              CH_R:    b0_nxt = 8'h0D;
              CH_B:    b0_nxt = 8'h08;
              CH_F:    b0_nxt = 8'h0C;
              default: b0_nxt = in_ch.in_byte;
            endcase
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (hv[4]) begin
            phase_nxt = PH_IDLE;
            code_nxt  = 16'h0000;
            n_nxt     = 2'd1;
            st0_nxt   = ST_ERR;
          end else begin
            code_nxt = cp;
            if (phase_r == PH_HEX4) begin
              phase_nxt = PH_BODY;
              v0_nxt    = 1'b1;
              if (cp < CP_2BYTE_MIN) begin
                n_nxt  = 2'd1;
                b0_nxt = cp[7:0];
              end else if (cp < CP_3BYTE_MIN) begin
                n_nxt  = 2'd2;
                b0_nxt = UTF8_LEAD2 | {3'b000, cp[10:6]};
                b1_nxt = UTF8_CONT | {2'b00, cp[5:0]};
              end else begin
                n_nxt  = 2'd3;
                b0_nxt = UTF8_LEAD3 | {4'h0, cp[15:12]};
                b1_nxt = UTF8_CONT | {2'b00, cp[11:6]};
                b2_nxt = UTF8_CONT | {2'b00, cp[5:0]};
              end
            end else begin
              phase_nxt = phase_t'(phase_r + 3'd1);
            end
          end
        end
        default: begin
          // idle, and the unused code treated as idle
          if (in_ch.in_byte == CH_QUOTE) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_IDLE;
            n_nxt     = 2'd1;
            st0_nxt   = ST_ERR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      code_r  <= 16'h0000;
      rem_r   <= 2'd0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      rem_r   <= n_nxt;
    end else if (out_xfer) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_byte_r   <= b0_nxt;
      s0_valid_r  <= v0_nxt;
      s0_status_r <= st0_nxt;
      s1_byte_r   <= b1_nxt;
      s2_byte_r   <= b2_nxt;
    end else if (out_xfer) begin
      // shift the next decoded byte forward
      s0_byte_r   <= s1_byte_r;
      s0_valid_r  <= 1'b1;
      s0_status_r <= ST_CONT;
      s1_byte_r   <= s2_byte_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/jsu_checker.sv
`default_nettype none
module jsu_checker
  import jsu_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_text_end,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       out_byte_valid,
  input wire [1:0] out_status,
  input wire       out_last
);

  // a stalled result is held with its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status)
      && $stable(out_last))
    else $error("result changed while stalled");

  // end of text gives a single error result in the next cycle
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_text_end |=> out_valid && out_last
      && out_status == ST_ERR)
    else $error("end of text did not give an error result");

  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid == (out_status == ST_CONT))
      && (out_byte_valid || out_byte == 8'h00))
    else $error("byte_valid and status disagree");

  // no new byte while results of the previous one remain behind this one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted with results still pending");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_text_end    (in_ch.text_end),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_status     (out_ch.status),
  .out_last       (out_ch.last)
);
`default_nettype wire
